// ===== hdl/scl_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial command line parser package
// Shared types, codes, keyword tables and default constants.
// ----------------------------------------------------------------------------
package scl_pkg;

    localparam int LINE_CAPACITY_DEF = 32;
    localparam int CARDINAL_MAX_DEF  = 3;

    localparam int KW_EXACT_LEN    = 8;
    localparam int MOVE_PREFIX_LEN = 12;
    localparam int NUMBER_START    = 12;
    localparam int CARDINAL_START  = 15;

    localparam logic [15:0] MAG_LIMIT      = 16'd32768;
    localparam logic [15:0] POS_LIMIT      = 16'd32767;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd50;
    localparam logic [15:0] IDLE_MAX       = 16'hFFFF;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [7:0] KW_STOP [KW_EXACT_LEN] =
        '{8'h43, 8'h4D, 8'h44, 8'h5F, 8'h53, 8'h54, 8'h4F, 8'h50};
    localparam logic [7:0] KW_SCAN [KW_EXACT_LEN] =
        '{8'h43, 8'h4D, 8'h44, 8'h5F, 8'h53, 8'h43, 8'h41, 8'h4E};
    localparam logic [7:0] KW_LOST [KW_EXACT_LEN] =
        '{8'h43, 8'h4D, 8'h44, 8'h5F, 8'h4C, 8'h4F, 8'h53, 8'h54};
    localparam logic [7:0] KW_MOVE [MOVE_PREFIX_LEN] =
        '{8'h43, 8'h4D, 8'h44, 8'h5F, 8'h4D, 8'h4F, 8'h56, 8'h45,
          8'h5F, 8'h54, 8'h4F, 8'h5F};

    typedef enum logic {
        ITEM_BYTE = 1'b0,
        ITEM_TICK = 1'b1
    } item_kind_t;

    typedef enum logic [2:0] {
        CODE_STOP    = 3'd0,
        CODE_SCAN    = 3'd1,
        CODE_LOST    = 3'd2,
        CODE_MOVE_TO = 3'd3,
        CODE_UNKNOWN = 3'd4
    } command_code_t;

    typedef enum logic [1:0] {
        NUM_SKIP   = 2'd0,
        NUM_DIGITS = 2'd1,
        NUM_DONE   = 2'd2
    } number_phase_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } scl_item_t;

    typedef struct packed {
        logic [2:0]         command_code;
        logic signed [15:0] target_position;
        logic [1:0]         cardinal_length;
        logic [7:0]         cardinal_first;
        logic [7:0]         cardinal_second;
        logic [7:0]         cardinal_third;
        logic               closed_by_timeout;
    } scl_result_t;

endpackage

// ===== hdl/scl_if.sv =====
// ----------------------------------------------------------------------------
// Serial command line parser channels
// Valid/ready interfaces for input items and result items.
// ----------------------------------------------------------------------------
interface scl_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

interface scl_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command_code;
    logic signed [15:0] target_position;
    logic [1:0]         cardinal_length;
    logic [7:0]         cardinal_first;
    logic [7:0]         cardinal_second;
    logic [7:0]         cardinal_third;
    logic               closed_by_timeout;

    modport source (
        output valid, output command_code, output target_position,
        output cardinal_length, output cardinal_first, output cardinal_second,
        output cardinal_third, output closed_by_timeout, input ready
    );
    modport sink (
        input valid, input command_code, input target_position,
        input cardinal_length, input cardinal_first, input cardinal_second,
        input cardinal_third, input closed_by_timeout, output ready
    );
endinterface

// ===== hdl/serial_command_line_parser.sv =====
// ----------------------------------------------------------------------------
// Serial command line parser
// Builds lines from received bytes and classifies each closed line.
//
// The items channel carries received bytes (cmd 0) and one millisecond ticks
// (cmd 1). A CR or LF that ends a non-empty line, or a tick that finds a
// non-empty line idle for longer than the timeout register, closes the line
// and yields one result item on the results channel. All other items yield
// nothing. An item passes an input register and then the line engine, which
// updates the match state and fills the result register in the same cycle.
// One item is taken every cycle while the result register is free or being
// emptied. When the receiver stalls, a waiting result blocks only the next
// item in the line engine; the input register still takes one more item.
// Reset empties both registers, clears the line, zeroes the idle counter
// and loads the timeout register with 50 ms.
// ----------------------------------------------------------------------------
module serial_command_line_parser #(
    parameter int LINE_CAPACITY = scl_pkg::LINE_CAPACITY_DEF,
    parameter int CARDINAL_MAX  = scl_pkg::CARDINAL_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    scl_in_if.sink      items,
    scl_out_if.source   results,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);
    import scl_pkg::*;

    scl_item_t   in_item;
    scl_item_t   item;
    logic        item_valid;
    logic        out_free;
    logic        step;
    logic        res_fire;
    scl_result_t result;
    scl_result_t res_out;

    assign in_item.cmd     = items.cmd;
    assign in_item.rx_byte = items.rx_byte;
    assign step            = item_valid && out_free;

    scl_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (items.valid),
        .in_ready   (items.ready),
        .in_item    (in_item),
        .consume    (step),
        .item_valid (item_valid),
        .item       (item)
    );

    scl_line_engine #(
        .LINE_CAPACITY (LINE_CAPACITY),
        .CARDINAL_MAX  (CARDINAL_MAX)
    ) u_line_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step      (step),
        .item      (item),
        .res_fire  (res_fire),
        .result    (result)
    );

    scl_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_fire),
        .res_in    (result),
        .free      (out_free),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .res_out   (res_out)
    );

    assign results.command_code      = res_out.command_code;
    assign results.target_position   = res_out.target_position;
    assign results.cardinal_length   = res_out.cardinal_length;
    assign results.cardinal_first    = res_out.cardinal_first;
    assign results.cardinal_second   = res_out.cardinal_second;
    assign results.cardinal_third    = res_out.cardinal_third;
    assign results.closed_by_timeout = res_out.closed_by_timeout;

endmodule

// ===== hdl/scl_in_stage.sv =====
// ----------------------------------------------------------------------------
// Input register
// Captures one item and holds it until the line engine consumes it.
// ----------------------------------------------------------------------------
module scl_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  scl_pkg::scl_item_t in_item,
    input  logic               consume,
    output logic               item_valid,
    output scl_pkg::scl_item_t item
);
    import scl_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    scl_item_t item_reg;

    assign in_ready   = !valid_reg || consume;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !consume);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== hdl/scl_line_engine.sv =====
// ----------------------------------------------------------------------------
// Line engine
// Incremental keyword match, number and cardinal capture, idle timing.
// ----------------------------------------------------------------------------
module scl_line_engine #(
    parameter int LINE_CAPACITY = scl_pkg::LINE_CAPACITY_DEF,
    parameter int CARDINAL_MAX  = scl_pkg::CARDINAL_MAX_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_wdata,
    input  logic                 step,
    input  scl_pkg::scl_item_t   item,
    output logic                 res_fire,
    output scl_pkg::scl_result_t result
);
    import scl_pkg::*;

    localparam int LW = $clog2(LINE_CAPACITY);
    localparam int CW = $clog2(CARDINAL_MAX + 1);
    localparam int CI = (CARDINAL_MAX > 1) ? $clog2(CARDINAL_MAX) : 1;

    logic [15:0]   timeout_reg;
    logic [15:0]   idle_reg, idle_next;
    logic [LW-1:0] len_reg, len_next;
    logic [3:0]    flags_reg, flags_next;
    logic [15:0]   acc_reg, acc_next;
    number_phase_t phase_reg, phase_next;
    logic          neg_reg, neg_next;
    logic [7:0]    card_reg [CARDINAL_MAX];
    logic [7:0]    card_next [CARDINAL_MAX];
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [7:0]    c;
    logic          is_digit;
    logic          is_space;
    logic [19:0]   acc_mul;
    logic          close_line;
    logic          by_timeout;

    assign c        = item.rx_byte;
    assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    assign is_space = (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_VT)
                      || (c == CHAR_FF);
    assign acc_mul  = 20'(acc_reg) * 20'd10 + 20'(c - CHAR_ZERO);

    always_comb
    begin
        idle_next  = idle_reg;
        len_next   = len_reg;
        flags_next = flags_reg;
        acc_next   = acc_reg;
        phase_next = phase_reg;
        neg_next   = neg_reg;
        card_next  = card_reg;
        cnt_next   = cnt_reg;
        close_line = 1'b0;
        by_timeout = 1'b0;

        if (item.cmd == ITEM_TICK)
        begin
            if (idle_reg != IDLE_MAX)
            begin
                idle_next = idle_reg + 16'd1;
            end
            if ((len_reg != '0) && (idle_next > timeout_reg))
            begin
                close_line = 1'b1;
                by_timeout = 1'b1;
            end
        end
        else
        begin
            idle_next = '0;
            if ((c == CHAR_LF) || (c == CHAR_CR))
            begin
                close_line = (len_reg != '0);
            end
            else if (len_reg < LW'(LINE_CAPACITY - 1))
            begin
                len_next = len_reg + 1'b1;
                if (len_reg < LW'(KW_EXACT_LEN))
                begin
                    if (c != KW_STOP[len_reg[2:0]]) flags_next[0] = 1'b0;
                    if (c != KW_SCAN[len_reg[2:0]]) flags_next[1] = 1'b0;
                    if (c != KW_LOST[len_reg[2:0]]) flags_next[2] = 1'b0;
                end
                else
                begin
                    flags_next[2:0] = 3'b000;
                end
                if ((len_reg < LW'(MOVE_PREFIX_LEN)) && (c != KW_MOVE[len_reg[3:0]]))
                begin
                    flags_next[3] = 1'b0;
                end

                if (len_reg >= LW'(NUMBER_START))
                begin
                    unique case (phase_reg)
                        NUM_SKIP:
                        begin
                            if (is_space)
                            begin
                                phase_next = NUM_SKIP;
                            end
                            else if ((c == CHAR_MINUS) || (c == CHAR_PLUS))
                            begin
                                neg_next   = (c == CHAR_MINUS);
                                phase_next = NUM_DIGITS;
                            end
                            else if (is_digit)
                            begin
                                acc_next   = 16'(c - CHAR_ZERO);
                                phase_next = NUM_DIGITS;
                            end
                            else
                            begin
                                phase_next = NUM_DONE;
                            end
                        end
                        NUM_DIGITS:
                        begin
                            if (is_digit)
                            begin
                                acc_next = (acc_mul > 20'(MAG_LIMIT)) ? MAG_LIMIT
                                                                       : acc_mul[15:0];
                            end
                            else
                            begin
                                phase_next = NUM_DONE;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end

                if ((len_reg >= LW'(CARDINAL_START)) && (int'(cnt_reg) < CARDINAL_MAX))
                begin
                    card_next[cnt_reg[CI-1:0]] = c;
                    cnt_next                   = cnt_reg + 1'b1;
                end
            end
        end

        if (close_line)
        begin
            len_next   = '0;
            flags_next = 4'hF;
            acc_next   = '0;
            phase_next = NUM_SKIP;
            neg_next   = 1'b0;
            cnt_next   = '0;
        end
    end

    always_comb
    begin
        result                   = '0;
        result.command_code      = CODE_UNKNOWN;
        result.closed_by_timeout = by_timeout;
        if ((len_reg == LW'(KW_EXACT_LEN)) && flags_reg[0])
        begin
            result.command_code = CODE_STOP;
        end
        else if ((len_reg == LW'(KW_EXACT_LEN)) && flags_reg[1])
        begin
            result.command_code = CODE_SCAN;
        end
        else if ((len_reg == LW'(KW_EXACT_LEN)) && flags_reg[2])
        begin
            result.command_code = CODE_LOST;
        end
        else if ((len_reg >= LW'(MOVE_PREFIX_LEN)) && flags_reg[3])
        begin
            result.command_code = CODE_MOVE_TO;
            if (neg_reg)
            begin
                result.target_position = -$signed(acc_reg);
            end
            else
            begin
                result.target_position = (acc_reg > POS_LIMIT) ? $signed(POS_LIMIT)
                                                                : $signed(acc_reg);
            end
            result.cardinal_length = (int'(cnt_reg) > 3) ? 2'd3 : 2'(cnt_reg);
            if (int'(cnt_reg) > 0) result.cardinal_first  = card_reg[0];
            if (int'(cnt_reg) > 1) result.cardinal_second = card_reg[1 % CARDINAL_MAX];
            if (int'(cnt_reg) > 2) result.cardinal_third  = card_reg[2 % CARDINAL_MAX];
        end
    end

    assign res_fire = step && close_line;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            timeout_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_reg  <= '0;
            len_reg   <= '0;
            flags_reg <= 4'hF;
            acc_reg   <= '0;
            phase_reg <= NUM_SKIP;
            neg_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (step)
        begin
            idle_reg  <= idle_next;
            len_reg   <= len_next;
            flags_reg <= flags_next;
            acc_reg   <= acc_next;
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            card_reg <= card_next;
        end
    end

endmodule

// ===== hdl/scl_out_stage.sv =====
// ----------------------------------------------------------------------------
// Result register
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module scl_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  scl_pkg::scl_result_t res_in,
    output logic                 free,
    output logic                 out_valid,
    input  logic                 out_ready,
    output scl_pkg::scl_result_t res_out
);
    import scl_pkg::*;

    logic        valid_reg;
    scl_result_t res_reg;

    assign free = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule
